>>> rtl/kvcd_pkg.sv
`default_nettype none

package kvcd_pkg;

   // Width of each length prefix, in bytes.
   localparam int LENGTH_BYTES = 4;

   // Command type codes.
   localparam logic [7:0] CODE_PUT    = 8'd1;
   localparam logic [7:0] CODE_DELETE = 8'd2;

   // Field tags carried with every word.
   localparam logic [2:0] KIND_TYPE    = 3'd0;
   localparam logic [2:0] KIND_KEY_LEN = 3'd1;
   localparam logic [2:0] KIND_KEY     = 3'd2;
   localparam logic [2:0] KIND_VAL_LEN = 3'd3;
   localparam logic [2:0] KIND_VAL     = 3'd4;
   localparam logic [2:0] KIND_IGNORED = 3'd5;

   // Verdict codes.
   localparam logic [1:0] VERDICT_NONE      = 2'd0;
   localparam logic [1:0] VERDICT_PUT       = 2'd1;
   localparam logic [1:0] VERDICT_DELETE    = 2'd2;
   localparam logic [1:0] VERDICT_MALFORMED = 2'd3;

   typedef enum logic [6:0] {
      PH_TYPE    = 7'b0000001,
      PH_KLEN    = 7'b0000010,
      PH_KBODY   = 7'b0000100,
      PH_VLEN    = 7'b0001000,
      PH_VBODY   = 7'b0010000,
      PH_SWALLOW = 7'b0100000,
      PH_DONE    = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [2:0] field_kind;
      logic       body_last;
      logic       done_res;
      logic [1:0] verdict;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/kvcd_step.sv
`default_nettype none

// Next-state and result logic for one command word.
module kvcd_step #(
   parameter int LENGTH_BYTES = kvcd_pkg::LENGTH_BYTES
) (
   input  wire kvcd_pkg::phase_type       phase_ff,
   input  wire                            put_ff,
   input  wire [8*LENGTH_BYTES-1:0]       gather_ff,
   input  wire [((LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1)-1:0] count_ff,
   input  wire [8*LENGTH_BYTES-1:0]       remain_ff,
   input  wire [7:0]                      data_byte,
   input  wire                            final_byte,
   output kvcd_pkg::phase_type            phase_in,
   output logic                           put_in,
   output logic [8*LENGTH_BYTES-1:0]      gather_in,
   output logic [((LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1)-1:0] count_in,
   output logic [8*LENGTH_BYTES-1:0]      remain_in,
   output kvcd_pkg::result_type           result
);

   localparam int LenW = 8 * LENGTH_BYTES;
   localparam int CntW = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
   localparam logic [CntW-1:0] CntLast = CntW'(LENGTH_BYTES - 1);

   logic [LenW-1:0] gathered;
   logic [LenW-1:0] remain_dec;

   assign gathered   = (gather_ff << 8) | LenW'(data_byte);
   assign remain_dec = remain_ff - LenW'(1);

   always_comb begin
      phase_in          = phase_ff;
      put_in            = put_ff;
      gather_in         = gather_ff;
      count_in          = count_ff;
      remain_in         = remain_ff;
      result.field_kind = kvcd_pkg::KIND_IGNORED;
      result.body_last  = 1'b0;
      result.done_res   = final_byte;
      result.verdict    = kvcd_pkg::VERDICT_NONE;

      unique case (phase_ff) inside
         kvcd_pkg::PH_TYPE: begin
            result.field_kind = kvcd_pkg::KIND_TYPE;
            put_in            = (data_byte == kvcd_pkg::CODE_PUT);
            gather_in         = '0;
            count_in          = '0;
            if ((data_byte == kvcd_pkg::CODE_PUT) || (data_byte == kvcd_pkg::CODE_DELETE)) begin
               phase_in = kvcd_pkg::PH_KLEN;
            end else begin
               phase_in = kvcd_pkg::PH_SWALLOW;
            end
         end
         kvcd_pkg::PH_KLEN, kvcd_pkg::PH_VLEN: begin
            result.field_kind = (phase_ff == kvcd_pkg::PH_KLEN) ? kvcd_pkg::KIND_KEY_LEN
                                                                 : kvcd_pkg::KIND_VAL_LEN;
            if (count_ff == CntLast) begin
               remain_in = gathered;
               gather_in = '0;
               count_in  = '0;
               if (gathered == '0) begin
                  // Empty body: skip straight past it.
                  phase_in = ((phase_ff == kvcd_pkg::PH_KLEN) && put_ff) ? kvcd_pkg::PH_VLEN
                                                                          : kvcd_pkg::PH_DONE;
               end else begin
                  phase_in = (phase_ff == kvcd_pkg::PH_KLEN) ? kvcd_pkg::PH_KBODY
                                                              : kvcd_pkg::PH_VBODY;
               end
            end else begin
               gather_in = gathered;
               count_in  = count_ff + CntW'(1);
            end
         end
         kvcd_pkg::PH_KBODY, kvcd_pkg::PH_VBODY: begin
            result.field_kind = (phase_ff == kvcd_pkg::PH_KBODY) ? kvcd_pkg::KIND_KEY
                                                                  : kvcd_pkg::KIND_VAL;
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               result.body_last = 1'b1;
               phase_in = ((phase_ff == kvcd_pkg::PH_KBODY) && put_ff) ? kvcd_pkg::PH_VLEN
                                                                        : kvcd_pkg::PH_DONE;
            end
         end
         default: begin
            // A word after a complete command, or anything after an error.
            phase_in = kvcd_pkg::PH_SWALLOW;
         end
      endcase

      if (final_byte) begin
         // Reaching the done phase implies no error was ever seen.
         if (phase_in == kvcd_pkg::PH_DONE) begin
            result.verdict = put_ff ? kvcd_pkg::VERDICT_PUT : kvcd_pkg::VERDICT_DELETE;
         end else begin
            result.verdict = kvcd_pkg::VERDICT_MALFORMED;
         end
         phase_in  = kvcd_pkg::PH_TYPE;
         put_in    = 1'b0;
         gather_in = '0;
         count_in  = '0;
         remain_in = '0;
      end
   end

endmodule

`default_nettype wire

>>> rtl/kv_command_deframer.sv
// Streaming deframer for length-prefixed key/value commands.
//
// The request channel (req_*) takes one word of an encoded command per
// handshake, with req_final_byte marking the last word of the command. The
// first word is the type (put or delete), followed by a big-endian key length
// of LENGTH_BYTES words, the key body, and for a put a value length and the
// value body. Every word comes back on the response channel (rsp_*) tagged
// with the field it belongs to; the word that ends a key or value body raises
// rsp_body_last. On the final word rsp_verdict gives put, delete or malformed.
//
// The response is registered, and the block takes one word per cycle unless
// the response stalls: the parse state is updated by a single layer of logic,
// and the only wide path is the body-length decrement of 8*LENGTH_BYTES bits.
// The response register parts the two sides; req_ready stays high while that
// register is empty or being drained, so a stalled receiver holds exactly one
// word and the request side waits only while the held word is not taken.
// Reset returns the parser to expecting a type word and empties the response
// register. After every final word the parser returns to that same state.
`default_nettype none

module kv_command_deframer #(
   parameter int LENGTH_BYTES = kvcd_pkg::LENGTH_BYTES
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire [7:0]  req_data_byte,
   input  wire        req_final_byte,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [7:0] rsp_byte_out,
   output logic [2:0] rsp_field_kind,
   output logic       rsp_body_last,
   output logic       rsp_done_res,
   output logic [1:0] rsp_verdict
);

   localparam int LenW = 8 * LENGTH_BYTES;
   localparam int CntW = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;

   // Parse state.
   kvcd_pkg::phase_type phase_ff, phase_in;
   logic                put_ff, put_in;
   logic [LenW-1:0]     gather_ff, gather_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic [LenW-1:0]     remain_ff, remain_in;

   // Response register.
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_byte_ff;
   kvcd_pkg::result_type rsp_result_ff;
   kvcd_pkg::result_type result;

   logic accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   kvcd_step #(
      .LENGTH_BYTES(LENGTH_BYTES)
   ) u_step (
      .phase_ff   (phase_ff),
      .put_ff     (put_ff),
      .gather_ff  (gather_ff),
      .count_ff   (count_ff),
      .remain_ff  (remain_ff),
      .data_byte  (req_data_byte),
      .final_byte (req_final_byte),
      .phase_in   (phase_in),
      .put_in     (put_in),
      .gather_in  (gather_in),
      .count_in   (count_in),
      .remain_in  (remain_in),
      .result     (result)
   );

   // Parse state advances only on an accepted word; rsp_valid_ff clears on drain.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= kvcd_pkg::PH_TYPE;
         put_ff       <= 1'b0;
         gather_ff    <= '0;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            put_ff    <= put_in;
            gather_ff <= gather_in;
            count_ff  <= count_in;
            remain_ff <= remain_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload needs no reset; it is qualified by rsp_valid.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_byte_ff   <= req_data_byte;
         rsp_result_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_out   = rsp_byte_ff;
   assign rsp_field_kind = rsp_result_ff.field_kind;
   assign rsp_body_last  = rsp_result_ff.body_last;
   assign rsp_done_res   = rsp_result_ff.done_res;
   assign rsp_verdict    = rsp_result_ff.verdict;

   // A held response must block the request side.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("word accepted while the response register is stalled");

   // A verdict is given exactly on the word that ends a command.
   a_verdict_on_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_done_res == (rsp_verdict != kvcd_pkg::VERDICT_NONE)))
      else $error("verdict does not match the final-word flag");

   // Only body words can end a body.
   a_last_in_body: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_body_last) |->
         ((rsp_field_kind == kvcd_pkg::KIND_KEY) || (rsp_field_kind == kvcd_pkg::KIND_VAL)))
      else $error("body end flagged outside a body");

   // The parser restarts after every final word.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_final_byte) |=> (phase_ff == kvcd_pkg::PH_TYPE))
      else $error("parser did not restart after a final word");

endmodule

`default_nettype wire
